/* hdl/mbrtu_pkg.sv */
// shared types, codes and crc helpers for the modbus rtu float read master
package mbrtu_pkg;

    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_BYTE    = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_RESP  = 2'd1;
    localparam logic [1:0] STATUS_CRC_FAIL = 2'd2;

    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_RESULT = 1'b1;

    localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
    localparam logic [7:0]  COUNT_HIGH      = 8'h00;
    localparam logic [7:0]  COUNT_LOW       = 8'h02;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [7:0]  SLAVE_RESET     = 8'h01;

    // response byte positions
    localparam logic [3:0] RX_VALUE_FIRST = 4'd3;
    localparam logic [3:0] RX_CRC_LOW     = 4'd7;
    localparam logic [3:0] RX_CRC_HIGH    = 4'd8;

    // request byte positions
    localparam logic [2:0] TX_SLAVE    = 3'd0;
    localparam logic [2:0] TX_FUNC     = 3'd1;
    localparam logic [2:0] TX_ADDR_HI  = 3'd2;
    localparam logic [2:0] TX_ADDR_LO  = 3'd3;
    localparam logic [2:0] TX_COUNT_HI = 3'd4;
    localparam logic [2:0] TX_COUNT_LO = 3'd5;
    localparam logic [2:0] TX_CRC_LO   = 3'd6;
    localparam logic [2:0] TX_CRC_HI   = 3'd7;

    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    localparam logic [15:0] NIB_TAB [16] = '{
        16'h0000, 16'hCC01, 16'hD801, 16'h1400, 16'hF001, 16'h3C00, 16'h2800, 16'hE401,
        16'hA001, 16'h6C00, 16'h7800, 16'hB401, 16'h5000, 16'h9C01, 16'h8801, 16'h4400
    };

    typedef struct packed {
        logic        is_result;
        logic [7:0]  slave_addr;
        logic [15:0] read_addr;
        logic [1:0]  status;
        logic [31:0] value;
    } job_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] t;
        t = (c >> 4) ^ NIB_TAB[c[3:0] ^ b[3:0]];
        return (t >> 4) ^ NIB_TAB[t[3:0] ^ b[7:4]];
    endfunction

endpackage

/* hdl/modbus_rtu_float_read_master.sv */
// top level of the modbus rtu float read master
// Channels: the input channel (in_valid/in_ready) takes one command per request:
// cmd 0 starts a read of two input registers at register_address, cmd 1 hands
// in a byte received from the bus, cmd 2 reports a receive timeout.
// The output channel (out_valid/out_ready) gives either a byte to transmit
// (kind 0, last marks the eighth frame byte) or a transaction result (kind 1,
// status and value_bits). The cfg channel writes the slave address and is always
// ready; the user must write it only while the block is idle, as the block itself
// does not enforce this. An accepted command is written into the job queue, and
// the back end moves it from there into the output register. Commands are
// accepted one per cycle while the four-entry job queue has room; the back end
// sends one frame byte per cycle while the receiver takes them, so a start
// command keeps it busy for eight bytes and builds the request CRC byte by byte.
// When the receiver stalls, the output register holds its item, the back end
// waits, and in_ready drops only once the job queue fills.
// Reset clears the queue, the output register and the response tracking, and
// sets the slave address to 1.
module modbus_rtu_float_read_master (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [15:0] register_address,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  tx_byte,
    output logic        last,
    output logic [1:0]  status,
    output logic [31:0] value_bits
);

    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    mbrtu_pkg::job_t q_in;
    mbrtu_pkg::job_t q_head;

    mbrtu_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .cmd              (cmd),
        .register_address (register_address),
        .rx_byte          (rx_byte),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_data           (q_in)
    );

    mbrtu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    mbrtu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .tx_byte    (tx_byte),
        .last       (last),
        .status     (status),
        .value_bits (value_bits)
    );

endmodule

/* hdl/mbrtu_front.sv */
// front end: accepts requests, tracks the response and queues jobs
module mbrtu_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          cmd,
    input  logic [15:0]         register_address,
    input  logic [7:0]          rx_byte,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data,
    input  logic                q_full,
    output logic                q_push,
    output mbrtu_pkg::job_t     q_data
);

    logic        waiting_reg, waiting_next;
    logic [3:0]  rx_count_reg, rx_count_next;
    logic [15:0] crc_reg, crc_next;
    logic [31:0] value_reg, value_next;
    logic [7:0]  crc_low_reg, crc_low_next;
    logic [7:0]  slave_reg;
    logic        accept;

    assign in_ready  = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        waiting_next  = waiting_reg;
        rx_count_next = rx_count_reg;
        crc_next      = crc_reg;
        value_next    = value_reg;
        crc_low_next  = crc_low_reg;
        q_push        = 1'b0;
        q_data        = '0;
        if (accept)
        begin
            case (cmd)
                mbrtu_pkg::CMD_START:
                begin
                    q_push           = 1'b1;
                    q_data.slave_addr = slave_reg;
                    q_data.read_addr = register_address;
                    waiting_next     = 1'b1;
                    rx_count_next    = '0;
                    crc_next         = mbrtu_pkg::CRC_INIT;
                    value_next       = '0;
                    crc_low_next     = '0;
                end
                mbrtu_pkg::CMD_BYTE:
                begin
                    if (waiting_reg)
                    begin
                        if (rx_count_reg < mbrtu_pkg::RX_CRC_LOW)
                        begin
                            crc_next = mbrtu_pkg::crc_byte(crc_reg, rx_byte);
                            if (rx_count_reg >= mbrtu_pkg::RX_VALUE_FIRST)
                            begin
                                value_next = {value_reg[23:0], rx_byte};
                            end
                            rx_count_next = rx_count_reg + 4'd1;
                        end
                        else if (rx_count_reg == mbrtu_pkg::RX_CRC_LOW)
                        begin
                            crc_low_next  = rx_byte;
                            rx_count_next = mbrtu_pkg::RX_CRC_HIGH;
                        end
                        else
                        begin
                            q_push           = 1'b1;
                            q_data.is_result = 1'b1;
                            if ({rx_byte, crc_low_reg} == crc_reg)
                            begin
                                q_data.status = mbrtu_pkg::STATUS_OK;
                                q_data.value  = value_reg;
                            end
                            else
                            begin
                                q_data.status = mbrtu_pkg::STATUS_CRC_FAIL;
                            end
                            waiting_next  = 1'b0;
                            rx_count_next = '0;
                        end
                    end
                end
                mbrtu_pkg::CMD_TIMEOUT:
                begin
                    if (waiting_reg)
                    begin
                        q_push           = 1'b1;
                        q_data.is_result = 1'b1;
                        q_data.status    = mbrtu_pkg::STATUS_NO_RESP;
                        waiting_next     = 1'b0;
                        rx_count_next    = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg  <= 1'b0;
            rx_count_reg <= '0;
            crc_reg      <= mbrtu_pkg::CRC_INIT;
            value_reg    <= '0;
            crc_low_reg  <= '0;
            slave_reg    <= mbrtu_pkg::SLAVE_RESET;
        end
        else
        begin
            waiting_reg  <= waiting_next;
            rx_count_reg <= rx_count_next;
            crc_reg      <= crc_next;
            value_reg    <= value_next;
            crc_low_reg  <= crc_low_next;
            if (cfg_valid && cfg_ready)
            begin
                slave_reg <= cfg_data;
            end
        end
    end

endmodule

/* hdl/mbrtu_queue.sv */
// small job queue between the front and back ends
module mbrtu_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mbrtu_pkg::job_t     push_data,
    input  logic                pop,
    output mbrtu_pkg::job_t     head,
    output logic                full,
    output logic                empty
);

    localparam int AW = mbrtu_pkg::QUEUE_AW;
    localparam int CW = mbrtu_pkg::QUEUE_AW + 1;

    mbrtu_pkg::job_t entry_reg [mbrtu_pkg::QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full  = (count_reg == CW'(mbrtu_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

/* hdl/mbrtu_back.sv */
// back end: serializes request frames and delivers results
module mbrtu_back (
    input  logic                clk,
    input  logic                rst_n,
    input  mbrtu_pkg::job_t     head,
    input  logic                q_empty,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                kind,
    output logic [7:0]          tx_byte,
    output logic                last,
    output logic [1:0]          status,
    output logic [31:0]         value_bits
);

    logic        busy_reg, busy_next;
    logic [2:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  sa_reg;
    logic [15:0] ra_reg;

    logic        out_valid_reg, out_valid_next;
    logic        kind_reg, kind_next;
    logic [7:0]  tx_byte_reg, tx_byte_next;
    logic        last_reg, last_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] value_reg, value_next;

    logic        load;
    logic        emit;
    logic [7:0]  cur_sa;
    logic [15:0] cur_ra;
    logic [2:0]  cur_idx;
    logic [15:0] cur_crc;
    logic [7:0]  cur_byte;

    assign load    = !out_valid_reg || out_ready;
    assign q_pop   = load && !busy_reg && !q_empty;
    assign emit    = load && (busy_reg || (!q_empty && !head.is_result));
    assign cur_sa  = busy_reg ? sa_reg  : head.slave_addr;
    assign cur_ra  = busy_reg ? ra_reg  : head.read_addr;
    assign cur_idx = busy_reg ? idx_reg : mbrtu_pkg::TX_SLAVE;
    assign cur_crc = busy_reg ? crc_reg : mbrtu_pkg::CRC_INIT;

    always_comb
    begin
        unique case (cur_idx)
            mbrtu_pkg::TX_SLAVE:    cur_byte = cur_sa;
            mbrtu_pkg::TX_FUNC:     cur_byte = mbrtu_pkg::FUNC_READ_INPUT;
            mbrtu_pkg::TX_ADDR_HI:  cur_byte = cur_ra[15:8];
            mbrtu_pkg::TX_ADDR_LO:  cur_byte = cur_ra[7:0];
            mbrtu_pkg::TX_COUNT_HI: cur_byte = mbrtu_pkg::COUNT_HIGH;
            mbrtu_pkg::TX_COUNT_LO: cur_byte = mbrtu_pkg::COUNT_LOW;
            mbrtu_pkg::TX_CRC_LO:   cur_byte = cur_crc[7:0];
            mbrtu_pkg::TX_CRC_HI:   cur_byte = cur_crc[15:8];
            default:                cur_byte = '0;
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        tx_byte_next   = tx_byte_reg;
        last_next      = last_reg;
        status_next    = status_reg;
        value_next     = value_reg;
        if (load)
        begin
            out_valid_next = 1'b0;
            if (emit)
            begin
                out_valid_next = 1'b1;
                kind_next      = mbrtu_pkg::KIND_TX;
                tx_byte_next   = cur_byte;
                last_next      = (cur_idx == mbrtu_pkg::TX_CRC_HI);
                status_next    = mbrtu_pkg::STATUS_OK;
                value_next     = '0;
                if (cur_idx < mbrtu_pkg::TX_CRC_LO)
                begin
                    crc_next = mbrtu_pkg::crc_byte(cur_crc, cur_byte);
                end
                idx_next  = cur_idx + 3'd1;
                busy_next = (cur_idx != mbrtu_pkg::TX_CRC_HI);
            end
            else if (q_pop)
            begin
                out_valid_next = 1'b1;
                kind_next      = mbrtu_pkg::KIND_RESULT;
                tx_byte_next   = '0;
                last_next      = 1'b0;
                status_next    = head.status;
                value_next     = head.value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            sa_reg <= head.slave_addr;
            ra_reg <= head.read_addr;
        end
        kind_reg    <= kind_next;
        tx_byte_reg <= tx_byte_next;
        last_reg    <= last_next;
        status_reg  <= status_next;
        value_reg   <= value_next;
        crc_reg     <= crc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign tx_byte    = tx_byte_reg;
    assign last       = last_reg;
    assign status     = status_reg;
    assign value_bits = value_reg;

`ifndef SYNTHESIS
    a_last_is_tx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> kind_reg == mbrtu_pkg::KIND_TX)
        else $error("last flag on a result");

    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && emit && idx_reg == mbrtu_pkg::TX_CRC_HI |=> !busy_reg && last_reg)
        else $error("frame did not close on its final byte");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !busy_reg && !q_empty)
        else $error("queue popped while sending or empty");

    a_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == mbrtu_pkg::KIND_RESULT |-> tx_byte_reg == '0)
        else $error("result carries a transmit byte");
`endif

endmodule
